/* design/rle_pkg.sv */
// ----------------------------------------------------------------------------
// Raft leader election package
// Shared codes, field types and the event record passed from front to back.
// ----------------------------------------------------------------------------
package rle_pkg;

    // Event kinds carried on the input tuser.
    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_START     = 3'd1;
    localparam logic [2:0] OP_PING_REQ  = 3'd2;
    localparam logic [2:0] OP_VOTE_REQ  = 3'd3;
    localparam logic [2:0] OP_PING_RSP  = 3'd4;
    localparam logic [2:0] OP_VOTE_RSP  = 3'd5;

    // Actions carried on the output tuser.
    localparam logic [1:0] ACT_NONE     = 2'd0;
    localparam logic [1:0] ACT_REPLY    = 2'd1;
    localparam logic [1:0] ACT_VOTE_ALL = 2'd2;
    localparam logic [1:0] ACT_PING_ALL = 2'd3;

    // Node roles.
    localparam logic [1:0] ROLE_FOLLOWER  = 2'd0;
    localparam logic [1:0] ROLE_CANDIDATE = 2'd1;
    localparam logic [1:0] ROLE_LEADER    = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [2:0] CFG_LOCAL_ID  = 3'd0;
    localparam logic [2:0] CFG_QUORUM    = 3'd1;
    localparam logic [2:0] CFG_TERM_LOW  = 3'd2;
    localparam logic [2:0] CFG_TERM_HIGH = 3'd3;
    localparam logic [2:0] CFG_ELEC_LOW  = 3'd4;
    localparam logic [2:0] CFG_ELEC_HIGH = 3'd5;
    localparam logic [2:0] CFG_WITNESS   = 3'd6;

    // One accepted event with its class.
    typedef struct packed {
        logic [2:0]  op;
        logic        use_elec;   // timeout drawn from the election window
        logic [47:0] now;
        logic [63:0] peer_id;
        logic [4:0]  peer_index;
        logic [63:0] peer_term;
        logic [63:0] peer_log_seq;
        logic [63:0] local_log_seq;
        logic        granted;
        logic [31:0] random_word;
    } event_t;

    // Configuration registers as seen by the back end.
    typedef struct packed {
        logic [63:0] local_id;
        logic [5:0]  quorum;
        logic [31:0] term_low_ms;
        logic [31:0] term_high_ms;
        logic [31:0] elec_low_ms;
        logic [31:0] elec_high_ms;
        logic        witness;
    } cfg_t;

endpackage

/* design/rle_front.sv */
// ----------------------------------------------------------------------------
// Raft leader election front end
// Accepts events, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module rle_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [343:0]      s_tdata,
    input  logic [2:0]        s_tuser,
    output logic              q_valid,
    input  logic              q_pop,
    output rle_pkg::event_t   q_item
);

    rle_pkg::event_t entry_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    rle_pkg::event_t in_item;
    logic            push;
    logic            pop;

    // Unpack and classify the incoming transfer.
    always_comb begin
        in_item.op            = s_tuser;
        in_item.use_elec      = (s_tuser == rle_pkg::OP_TICK);
        in_item.now           = s_tdata[47:0];
        in_item.peer_id       = s_tdata[111:48];
        in_item.peer_index    = s_tdata[116:112];
        in_item.peer_term     = s_tdata[180:117];
        in_item.peer_log_seq  = s_tdata[244:181];
        in_item.local_log_seq = s_tdata[308:245];
        in_item.granted       = s_tdata[309];
        in_item.random_word   = s_tdata[341:310];
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_item   = entry_reg[rd_ptr_reg];

    // Queue pointers and fill count.
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

/* design/rle_back.sv */
// ----------------------------------------------------------------------------
// Raft leader election back end
// Draws the randomised timeout with a bit-serial remainder, then applies the
// event to the election state and registers the result.
// ----------------------------------------------------------------------------
module rle_back #(
    parameter int MAX_MEMBERS = 32,
    parameter int TIME_BITS   = 48
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  rle_pkg::cfg_t     cfg,
    input  logic              q_valid,
    output logic              q_pop,
    input  rle_pkg::event_t   q_item,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [263:0]      m_tdata,
    output logic [1:0]        m_tuser
);

    localparam int IW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_APPLY} state_t;

    state_t                 state_reg;
    rle_pkg::event_t        item_reg;
    logic [31:0]            low_reg;
    logic [31:0]            span_reg;
    logic [31:0]            rem_reg;
    logic [31:0]            dvd_reg;
    logic [5:0]             cnt_reg;

    logic [1:0]             role_reg, role_next;
    logic [63:0]            term_reg, term_next;
    logic [63:0]            leader_reg, leader_next;
    logic [63:0]            vote_reg, vote_next;
    logic [5:0]             vcount_reg, vcount_next;
    logic [TIME_BITS-1:0]   dl_reg, dl_next;
    logic [MAX_MEMBERS-1:0] voted_reg, voted_next;

    logic                   out_valid_reg;
    logic [1:0]             act_next;
    logic                   grant_next;

    logic [31:0]            sel_low;
    logic [31:0]            sel_high;
    logic [32:0]            rem_shift;
    logic [31:0]            pick;
    logic [TIME_BITS-1:0]   now_t;
    logic [TIME_BITS-1:0]   dl_pick;
    logic [TIME_BITS-1:0]   dl_ping;
    logic [TIME_BITS-1:0]   dl_start;
    logic [6:0]             slot_ext;
    logic                   slot_ok;
    logic [IW-1:0]          slot_idx;
    logic                   commit;

    // Timeout window chosen by event class.
    assign sel_low   = q_item.use_elec ? cfg.elec_low_ms : cfg.term_low_ms;
    assign sel_high  = q_item.use_elec ? cfg.elec_high_ms : cfg.term_high_ms;
    assign rem_shift = {rem_reg, dvd_reg[31]};
    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign commit    = (state_reg == S_APPLY) && (!out_valid_reg || m_tready);

    // Candidate deadlines for this event.
    always_comb begin
        pick     = (span_reg == 32'd0) ? low_reg : low_reg + rem_reg;
        now_t    = TIME_BITS'(item_reg.now);
        dl_pick  = now_t + TIME_BITS'(pick);
        dl_ping  = now_t + TIME_BITS'(cfg.term_low_ms);
        dl_start = now_t + TIME_BITS'(cfg.term_high_ms);
        slot_ext = {2'b00, item_reg.peer_index};
        slot_ok  = (slot_ext < 7'(MAX_MEMBERS));
        slot_idx = IW'(slot_ext);
    end

    // Election state update for one event.
    always_comb begin
        role_next   = role_reg;
        term_next   = term_reg;
        leader_next = leader_reg;
        vote_next   = vote_reg;
        vcount_next = vcount_reg;
        dl_next     = dl_reg;
        voted_next  = voted_reg;
        act_next    = rle_pkg::ACT_NONE;
        grant_next  = 1'b0;
        case (item_reg.op)
            rle_pkg::OP_TICK: begin
                if (now_t >= dl_reg) begin
                    if (role_reg == rle_pkg::ROLE_CANDIDATE &&
                        vcount_reg >= cfg.quorum) begin
                        role_next   = rle_pkg::ROLE_LEADER;
                        dl_next     = dl_ping;
                        vote_next   = 64'd0;
                        vcount_next = 6'd0;
                        leader_next = cfg.local_id;
                        act_next    = rle_pkg::ACT_PING_ALL;
                    end else if (role_reg == rle_pkg::ROLE_LEADER) begin
                        dl_next  = dl_ping;
                        act_next = rle_pkg::ACT_PING_ALL;
                    end else if (!cfg.witness) begin
                        term_next   = term_reg + 64'd1;
                        role_next   = rle_pkg::ROLE_CANDIDATE;
                        dl_next     = dl_pick;
                        vote_next   = cfg.local_id;
                        vcount_next = 6'd1;
                        leader_next = 64'd0;
                        voted_next  = '0;
                        act_next    = rle_pkg::ACT_VOTE_ALL;
                    end
                end
            end
            rle_pkg::OP_START: begin
                role_next   = rle_pkg::ROLE_FOLLOWER;
                vcount_next = 6'd0;
                vote_next   = 64'd0;
                leader_next = 64'd0;
                dl_next     = dl_start;
            end
            rle_pkg::OP_PING_REQ: begin
                act_next = rle_pkg::ACT_REPLY;
                if (item_reg.peer_term >= term_reg) begin
                    if (item_reg.peer_term > term_reg) begin
                        leader_next = item_reg.peer_id;
                        term_next   = item_reg.peer_term;
                        role_next   = rle_pkg::ROLE_FOLLOWER;
                        vote_next   = 64'd0;
                        vcount_next = 6'd0;
                        voted_next  = '0;
                        dl_next     = dl_pick;
                    end
                    if (leader_next == 64'd0 || leader_next == item_reg.peer_id) begin
                        leader_next = item_reg.peer_id;
                        dl_next     = dl_pick;
                        grant_next  = 1'b1;
                    end
                end
            end
            rle_pkg::OP_VOTE_REQ: begin
                act_next = rle_pkg::ACT_REPLY;
                if (item_reg.peer_term >= term_reg) begin
                    if (item_reg.peer_term > term_reg) begin
                        term_next   = item_reg.peer_term;
                        leader_next = 64'd0;
                        role_next   = rle_pkg::ROLE_FOLLOWER;
                        vote_next   = 64'd0;
                        vcount_next = 6'd0;
                        voted_next  = '0;
                        dl_next     = dl_pick;
                    end
                    if (role_next == rle_pkg::ROLE_FOLLOWER &&
                        (vote_next == 64'd0 || vote_next == item_reg.peer_id) &&
                        item_reg.peer_log_seq >= item_reg.local_log_seq) begin
                        grant_next = 1'b1;
                        vote_next  = item_reg.peer_id;
                        dl_next    = dl_pick;
                    end
                end
            end
            rle_pkg::OP_PING_RSP, rle_pkg::OP_VOTE_RSP: begin
                if (item_reg.peer_term > term_reg) begin
                    term_next   = item_reg.peer_term;
                    leader_next = (item_reg.op == rle_pkg::OP_PING_RSP) ?
                                  item_reg.peer_id : 64'd0;
                    role_next   = rle_pkg::ROLE_FOLLOWER;
                    vote_next   = 64'd0;
                    vcount_next = 6'd0;
                    voted_next  = '0;
                    dl_next     = dl_pick;
                end else if (item_reg.op == rle_pkg::OP_VOTE_RSP &&
                             item_reg.peer_term == term_reg && item_reg.granted &&
                             role_reg == rle_pkg::ROLE_CANDIDATE && slot_ok &&
                             !voted_reg[slot_idx]) begin
                    voted_next[slot_idx] = 1'b1;
                    vcount_next          = vcount_reg + 6'd1;
                    if (vcount_next >= cfg.quorum) begin
                        role_next   = rle_pkg::ROLE_LEADER;
                        dl_next     = dl_ping;
                        vote_next   = 64'd0;
                        vcount_next = 6'd0;
                        leader_next = cfg.local_id;
                        act_next    = rle_pkg::ACT_PING_ALL;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer, remainder unit, election state and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            role_reg      <= rle_pkg::ROLE_FOLLOWER;
            term_reg      <= 64'd0;
            leader_reg    <= 64'd0;
            vote_reg      <= 64'd0;
            vcount_reg    <= 6'd0;
            dl_reg        <= '0;
            voted_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            // A new result replaces the old one, otherwise a taken result clears.
            if (commit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        item_reg  <= q_item;
                        low_reg   <= sel_low;
                        span_reg  <= sel_high - sel_low;
                        rem_reg   <= 32'd0;
                        dvd_reg   <= q_item.random_word;
                        cnt_reg   <= 6'd32;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    // One quotient bit per cycle.
                    if (rem_shift >= {1'b0, span_reg}) begin
                        rem_reg <= 32'(rem_shift - {1'b0, span_reg});
                    end else begin
                        rem_reg <= rem_shift[31:0];
                    end
                    dvd_reg <= {dvd_reg[30:0], 1'b0};
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1) begin
                        state_reg <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    if (commit) begin
                        role_reg      <= role_next;
                        term_reg      <= term_next;
                        leader_reg    <= leader_next;
                        vote_reg      <= vote_next;
                        vcount_reg    <= vcount_next;
                        dl_reg        <= dl_next;
                        voted_reg     <= voted_next;
                        m_tuser       <= act_next;
                        m_tdata       <= {5'd0, vote_next, leader_next, term_next, role_next,
                                          (act_next == rle_pkg::ACT_REPLY) ? term_next : 64'd0,
                                          grant_next};
                        state_reg     <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;

    // A result appears only from a committed event.
    a_result_from_apply: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == S_APPLY))
        else $error("result raised outside the apply step");

    // A leader never holds a vote.
    a_leader_no_vote: assert property (@(posedge aclk) disable iff (!aresetn)
        role_reg == rle_pkg::ROLE_LEADER |-> vote_reg == 64'd0)
        else $error("leader holds a vote");

    // The queue is drained only while the sequencer is free.
    a_pop_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> state_reg == S_DIV)
        else $error("event taken while busy");

endmodule

/* design/raft_leader_election.sv */
// ----------------------------------------------------------------------------
// Raft leader election
// Election state machine for one cluster member with a configuration port.
// ----------------------------------------------------------------------------
// Events enter on the s_ channel (kind on s_tuser) and each gives exactly
// one result on the m_ channel (action on m_tuser, role, term, leader and
// vote snapshot on m_tdata).
// An event goes from its input transfer to its result in order: it leaves
// the queue, the bit-serial remainder randomises the timeout, and the apply
// step applies the event and registers the result. One event is worked at a
// time; the back end takes no new event until the current one is applied.
// A two-entry queue behind the input lets up to two events wait while the
// back end works; when it is full s_tready drops.
// A result waits in the output register while m_tready is low; the back end
// holds its next event until that register is free.
// Reset (aresetn low, synchronous) gives a follower at term zero with no
// leader, no vote, a zero deadline and the register reset values.
// Configuration registers are written by cfg_wr_en, cfg_index, cfg_data; the
// user must do so while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module raft_leader_election #(
    parameter int MAX_MEMBERS = 32,
    parameter int TIME_BITS   = 48
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // now, peer_id, peer_index, peer_term, peer_log_seq, local_log_seq,
    // granted, random_word
    input  logic [343:0] s_tdata,
    // op
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // reply_granted, reply_term, role, current_term, known_leader, voted_for
    output logic [263:0] m_tdata,
    // action
    output logic [1:0]   m_tuser
);

    rle_pkg::cfg_t   cfg_reg;
    logic            q_valid;
    logic            q_pop;
    rle_pkg::event_t q_item;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.local_id     <= 64'd0;
            cfg_reg.quorum       <= 6'd1;
            cfg_reg.term_low_ms  <= 32'd1000;
            cfg_reg.term_high_ms <= 32'd2000;
            cfg_reg.elec_low_ms  <= 32'd500;
            cfg_reg.elec_high_ms <= 32'd1000;
            cfg_reg.witness      <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rle_pkg::CFG_LOCAL_ID:  cfg_reg.local_id     <= cfg_data;
                rle_pkg::CFG_QUORUM:    cfg_reg.quorum       <= cfg_data[5:0];
                rle_pkg::CFG_TERM_LOW:  cfg_reg.term_low_ms  <= cfg_data[31:0];
                rle_pkg::CFG_TERM_HIGH: cfg_reg.term_high_ms <= cfg_data[31:0];
                rle_pkg::CFG_ELEC_LOW:  cfg_reg.elec_low_ms  <= cfg_data[31:0];
                rle_pkg::CFG_ELEC_HIGH: cfg_reg.elec_high_ms <= cfg_data[31:0];
                rle_pkg::CFG_WITNESS:   cfg_reg.witness      <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    rle_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    rle_back #(
        .MAX_MEMBERS (MAX_MEMBERS),
        .TIME_BITS   (TIME_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* tb/raft_leader_election_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Raft leader election testbench
// Drives election events through the input stream and compares every result
// against a cycle-free election model kept inside the testbench.
// ----------------------------------------------------------------------------
module raft_leader_election_tb;

    localparam int MEMBERS = 32;
    localparam logic [47:0] TMASK = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [2:0]  op;
        logic [47:0] now;
        logic [63:0] peer_id;
        logic [4:0]  peer_index;
        logic [63:0] peer_term;
        logic [63:0] peer_log_seq;
        logic [63:0] local_log_seq;
        logic        granted;
        logic [31:0] random_word;
    } ev_t;

    typedef struct packed {
        logic [1:0]  action;
        logic        reply_granted;
        logic [63:0] reply_term;
        logic [1:0]  role;
        logic [63:0] current_term;
        logic [63:0] known_leader;
        logic [63:0] voted_for;
    } res_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [63:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [343:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [263:0] m_tdata;
    logic [1:0]   m_tuser;

    raft_leader_election dut (.*);

    always #1 aclk = ~aclk;

    // Model configuration.
    logic [63:0] c_id;
    logic [5:0]  c_quorum;
    logic [31:0] c_tlo, c_thi, c_elo, c_ehi;
    logic        c_wit;
    // Model state.
    logic [1:0]  n_role;
    logic [63:0] n_term, n_leader, n_vote;
    logic [5:0]  n_count;
    logic [47:0] n_dl;
    logic [MEMBERS-1:0] n_voted;

    ev_t  pending_events[$];
    res_t expected_results[$];
    int   failures = 0;
    int   send_idle = 23, recv_idle = 61;

    function automatic logic [47:0] later(logic [47:0] now, logic [31:0] ms);
        return (now + {16'd0, ms}) & TMASK;
    endfunction

    function automatic logic [31:0] draw(logic [31:0] lo, logic [31:0] hi,
                                         logic [31:0] rnd);
        logic [31:0] span;
        span = hi - lo;
        if (span == 32'd0) return lo;
        return lo + (rnd % span);
    endfunction

    function automatic void to_follower(logic [47:0] now, logic [31:0] rnd);
        n_role = rle_pkg::ROLE_FOLLOWER;
        n_dl = later(now, draw(c_tlo, c_thi, rnd));
        n_vote = 64'd0;
        n_count = 6'd0;
        n_voted = '0;
    endfunction

    function automatic void to_candidate(logic [47:0] now, logic [31:0] rnd,
                                         inout logic [1:0] act);
        if (!c_wit) begin
            n_term = n_term + 64'd1;
            n_role = rle_pkg::ROLE_CANDIDATE;
            n_dl = later(now, draw(c_elo, c_ehi, rnd));
            n_vote = c_id;
            n_count = 6'd1;
            n_leader = 64'd0;
            n_voted = '0;
            act = rle_pkg::ACT_VOTE_ALL;
        end
    endfunction

    function automatic void to_leader(logic [47:0] now, inout logic [1:0] act);
        n_role = rle_pkg::ROLE_LEADER;
        n_dl = later(now, c_tlo);
        n_vote = 64'd0;
        n_count = 6'd0;
        n_leader = c_id;
        act = rle_pkg::ACT_PING_ALL;
    endfunction

    // Election model: one result per event.
    function automatic res_t election_step(ev_t e);
        res_t r;
        logic [1:0] act;
        logic g;
        act = rle_pkg::ACT_NONE;
        g = 1'b0;
        case (e.op)
            rle_pkg::OP_TICK: begin
                if (e.now >= n_dl) begin
                    if (n_role == rle_pkg::ROLE_FOLLOWER) begin
                        to_candidate(e.now, e.random_word, act);
                    end else if (n_role == rle_pkg::ROLE_CANDIDATE) begin
                        if (n_count >= c_quorum) to_leader(e.now, act);
                        else to_candidate(e.now, e.random_word, act);
                    end else begin
                        n_dl = later(e.now, c_tlo);
                        act = rle_pkg::ACT_PING_ALL;
                    end
                end
            end
            rle_pkg::OP_START: begin
                n_role = rle_pkg::ROLE_FOLLOWER;
                n_count = 6'd0;
                n_vote = 64'd0;
                n_leader = 64'd0;
                n_dl = later(e.now, c_thi);
            end
            rle_pkg::OP_PING_REQ: begin
                act = rle_pkg::ACT_REPLY;
                if (e.peer_term >= n_term) begin
                    if (e.peer_term > n_term) begin
                        n_leader = e.peer_id;
                        n_term = e.peer_term;
                        to_follower(e.now, e.random_word);
                    end
                    if (!(n_leader != 64'd0 && n_leader != e.peer_id)) begin
                        n_leader = e.peer_id;
                        n_dl = later(e.now, draw(c_tlo, c_thi, e.random_word));
                        g = 1'b1;
                    end
                end
            end
            rle_pkg::OP_VOTE_REQ: begin
                act = rle_pkg::ACT_REPLY;
                if (e.peer_term >= n_term) begin
                    if (e.peer_term > n_term) begin
                        n_term = e.peer_term;
                        n_leader = 64'd0;
                        to_follower(e.now, e.random_word);
                    end
                    if (n_role == rle_pkg::ROLE_FOLLOWER &&
                        (n_vote == 64'd0 || n_vote == e.peer_id)
                        && e.peer_log_seq >= e.local_log_seq) begin
                        g = 1'b1;
                        n_vote = e.peer_id;
                        n_dl = later(e.now, draw(c_tlo, c_thi, e.random_word));
                    end
                end
            end
            rle_pkg::OP_PING_RSP: begin
                if (e.peer_term > n_term) begin
                    n_term = e.peer_term;
                    n_leader = e.peer_id;
                    to_follower(e.now, e.random_word);
                end
            end
            rle_pkg::OP_VOTE_RSP: begin
                if (e.peer_term > n_term) begin
                    n_term = e.peer_term;
                    n_leader = 64'd0;
                    to_follower(e.now, e.random_word);
                end else if (e.peer_term == n_term && e.granted &&
                             n_role == rle_pkg::ROLE_CANDIDATE &&
                             !n_voted[e.peer_index]) begin
                    n_voted[e.peer_index] = 1'b1;
                    n_count = n_count + 6'd1;
                    if (n_count >= c_quorum) to_leader(e.now, act);
                end
            end
            default: ;
        endcase
        r.action = act;
        r.reply_granted = g;
        r.reply_term = (act == rle_pkg::ACT_REPLY) ? n_term : 64'd0;
        r.role = n_role;
        r.current_term = n_term;
        r.known_leader = n_leader;
        r.voted_for = n_vote;
        return r;
    endfunction

    // Driver: moves the pending events onto the input stream.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready) begin
                if (pending_events.size() > 0 && $urandom_range(99) >= send_idle) begin
                    ev_t e;
                    e = pending_events.pop_front();
                    expected_results.push_back(election_step(e));
                    s_tvalid <= 1'b1;
                    s_tuser <= e.op;
                    s_tdata <= {2'b00, e.random_word, e.granted, e.local_log_seq,
                                e.peer_log_seq, e.peer_term, e.peer_index,
                                e.peer_id, e.now};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every result transfer against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                res_t got, exp_r;
                got.action        = m_tuser;
                got.reply_granted = m_tdata[0];
                got.reply_term    = m_tdata[64:1];
                got.role          = m_tdata[66:65];
                got.current_term  = m_tdata[130:67];
                got.known_leader  = m_tdata[194:131];
                got.voted_for     = m_tdata[258:195];
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $realtime, got);
                    failures++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r || m_tdata[263:259] !== 5'd0) begin
                        $display("%0t: mismatch expected %h actual %h", $realtime,
                                 exp_r, got);
                        failures++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            rle_pkg::CFG_LOCAL_ID:  c_id = val;
            rle_pkg::CFG_QUORUM:    c_quorum = val[5:0];
            rle_pkg::CFG_TERM_LOW:  c_tlo = val[31:0];
            rle_pkg::CFG_TERM_HIGH: c_thi = val[31:0];
            rle_pkg::CFG_ELEC_LOW:  c_elo = val[31:0];
            rle_pkg::CFG_ELEC_HIGH: c_ehi = val[31:0];
            default:                c_wit = val[0];
        endcase
    endtask

    task automatic drain;
        while (pending_events.size() != 0 || expected_results.size() != 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    // Event with a mostly small time base and terms near the current one.
    function automatic ev_t random_event(logic [47:0] base);
        ev_t e;
        e.op = ($urandom_range(19) == 0) ? 3'(6 + $urandom_range(1))
                                         : 3'($urandom_range(5));
        e.now = ($urandom_range(29) == 0) ? 48'({$urandom, $urandom}) : base;
        e.peer_id = ($urandom_range(9) == 0) ? {$urandom, $urandom}
                                             : 64'($urandom_range(4));
        e.peer_index = 5'($urandom);
        case ($urandom_range(5))
            0: e.peer_term = {$urandom, $urandom};
            1: e.peer_term = n_term + 64'd1;
            default: e.peer_term = n_term - 64'($urandom_range(1));
        endcase
        e.peer_log_seq = ($urandom_range(3) == 0) ? {$urandom, $urandom}
                                                  : 64'($urandom_range(3));
        e.local_log_seq = ($urandom_range(3) == 0) ? {$urandom, $urandom}
                                                   : 64'($urandom_range(3));
        e.granted = ($urandom_range(3) != 0);
        e.random_word = $urandom;
        return e;
    endfunction

    initial begin
        ev_t e;
        logic [47:0] clock_ms;
        c_id = 0; c_quorum = 1; c_tlo = 1000; c_thi = 2000;
        c_elo = 500; c_ehi = 1000; c_wit = 0;
        n_role = rle_pkg::ROLE_FOLLOWER; n_term = 0; n_leader = 0; n_vote = 0;
        n_count = 0; n_dl = 0; n_voted = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: extremes, every event kind and the special cases.
        write_reg(rle_pkg::CFG_LOCAL_ID, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(rle_pkg::CFG_QUORUM, 64'd3);
        e = '0; e.op = rle_pkg::OP_START; e.now = 48'd10; pending_events.push_back(e);
        e.op = rle_pkg::OP_TICK; e.now = 48'd5000; e.random_word = 32'hFFFF_FFFF;
        pending_events.push_back(e);
        e.op = rle_pkg::OP_VOTE_RSP; e.peer_term = 64'd1; e.granted = 1;
        e.peer_index = 31;
        pending_events.push_back(e);
        pending_events.push_back(e);                       // repeated slot ignored
        e.peer_index = 0; pending_events.push_back(e);     // reaches quorum
        e.op = rle_pkg::OP_PING_REQ; e.peer_id = 64'd7; pending_events.push_back(e);
        e.peer_id = 64'd9; pending_events.push_back(e);    // conflicting leader
        e.op = rle_pkg::OP_TICK; e.now = TMASK; pending_events.push_back(e);
        e.op = rle_pkg::OP_VOTE_REQ; e.peer_term = 64'hFFFF_FFFF_FFFF_FFFF;
        e.peer_log_seq = '1; e.local_log_seq = '1; pending_events.push_back(e);
        e.op = rle_pkg::OP_VOTE_REQ; e.peer_id = 64'd3; pending_events.push_back(e);
        e.op = rle_pkg::OP_PING_RSP; e.peer_term = 64'd0; pending_events.push_back(e);
        e.op = rle_pkg::OP_TICK; e.now = '1; pending_events.push_back(e);  // term wraps
        e.op = 3'd7; e.granted = 0; pending_events.push_back(e);
        e.op = 3'd6; pending_events.push_back(e);
        drain();

        write_reg(rle_pkg::CFG_WITNESS, 64'd1);
        e = '0; e.op = rle_pkg::OP_TICK; e.now = '1; pending_events.push_back(e);
        drain();

        // Random phases over several settings, extremes among them.
        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 2) begin send_idle = 61; recv_idle = 23; end
            if (phase == 4) begin send_idle = 0; recv_idle = 0; end
            write_reg(rle_pkg::CFG_LOCAL_ID,
                      (phase == 1) ? 64'd0 : 64'($urandom_range(4) + 1));
            write_reg(rle_pkg::CFG_QUORUM, (phase == 3) ? 64'd0 : (phase == 5) ? 64'd63
                                           : 64'($urandom_range(1, 4)));
            write_reg(rle_pkg::CFG_TERM_LOW,
                      (phase == 5) ? 64'hFFFF_FFFF : 64'($urandom_range(50)));
            write_reg(rle_pkg::CFG_TERM_HIGH,
                      (phase == 1) ? 64'd0 : 64'($urandom_range(200)));
            write_reg(rle_pkg::CFG_ELEC_LOW,
                      (phase == 3) ? 64'hFFFF_FFFF : 64'($urandom_range(30)));
            write_reg(rle_pkg::CFG_ELEC_HIGH,
                      (phase == 4) ? 64'd0 : 64'($urandom_range(100)));
            write_reg(rle_pkg::CFG_WITNESS, (phase == 2) ? 64'd1 : 64'd0);
            clock_ms = 48'($urandom_range(1000));
            for (int k = 0; k < 320; k++) begin
                while (pending_events.size() >= 4) @(posedge aclk);
                clock_ms = clock_ms + 48'($urandom_range(60));
                pending_events.push_back(random_event(clock_ms));
            end
            drain();
        end

        if (failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule

/* raft_leader_election.f */
design/rle_pkg.sv
design/rle_front.sv
design/rle_back.sv
design/raft_leader_election.sv
tb/raft_leader_election_tb.sv
